// ----- hdl/fss_pkg.sv -----
`default_nettype none

package fss_pkg;

   // fixed field widths
   localparam int POS_W  = 48;
   localparam int SPD_W  = 32;
   localparam int SHOT_W = 16;
   localparam int TICK_W = 17;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 2;
   localparam int TOL_W  = 31;
   localparam int PROD_W = 56;

   localparam int HISTORY_DEPTH_DEFAULT = 8;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_INVERSE   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_TOLERANCE = 2'd2;

   localparam logic [15:0]       TIMEOUT_RESET   = 16'd200;
   localparam logic [31:0]       INVERSE_RESET   = 32'd1872457;
   localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 31'd655360;

   localparam logic signed [SPD_W-1:0] SPEED_ONE = 32'sd65536;
   localparam logic signed [SPD_W-1:0] SPEED_TEN = 32'sd655360;
   localparam logic [TICK_W-1:0]       TICKS_MAX = 17'h1FFFF;
   localparam logic [SHOT_W-1:0]       SHOTS_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      LS_PASS,
      LS_SPINDOWN,
      LS_SPINUP,
      LS_INCREMENT,
      LS_NEGEDGE
   } latch_state_type;

   typedef struct packed {
      logic                     goal_present;
      logic signed [SPD_W-1:0]  goal_velocity;
      logic                     aim_forward;
      logic                     lamp_override;
      logic                     push_request;
      logic                     clamp_request;
      logic                     output_enabled;
      logic signed [POS_W-1:0]  position_left;
      logic signed [POS_W-1:0]  position_right;
      logic signed [SPD_W-1:0]  velocity_left;
      logic signed [SPD_W-1:0]  velocity_right;
   } req_word_type;

   typedef struct packed {
      logic                     ready_both;
      logic                     ready_left;
      logic                     ready_right;
      logic signed [SPD_W-1:0]  average_left;
      logic signed [SPD_W-1:0]  average_right;
      logic [SHOT_W-1:0]        shot_count;
      logic                     drive_valid;
      logic                     lamp_on;
      logic                     forward_light;
      logic                     backward_light;
      logic                     clamp_drive;
      logic                     push_drive;
   } rsp_word_type;

   // per-tick flags carried alongside the speed pipeline
   typedef struct packed {
      logic                     drive_valid;
      logic                     clamp;
      logic                     push;
      logic                     forwards;
      logic                     force_lights;
      logic                     goal_nonzero;
      logic                     goal_small;
      logic                     goal_big;
      logic                     spin_low;
      logic                     spin_high;
      logic signed [SPD_W-1:0]  held_goal;
   } side_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } pipe_en_type;

   typedef struct packed {
      logic              lamp_on;
      logic              forward_light;
      logic              backward_light;
      logic              clamp_drive;
      logic              push_drive;
      logic [SHOT_W-1:0] shot_count;
   } drive_type;

endpackage

`default_nettype wire

// ----- hdl/fss_chan_if.sv -----
`default_nettype none

interface fss_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/fss_ring.sv -----
`default_nettype none

module fss_ring
   import fss_pkg::*;
#(
   parameter int DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [POS_W-1:0] pos_left,
   input  wire logic [POS_W-1:0] pos_right,
   output logic [POS_W-1:0]      old_left,
   output logic [POS_W-1:0]      old_right
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [POS_W-1:0]  mem_left [DEPTH];
   logic [POS_W-1:0]  mem_right [DEPTH];
   logic [DEPTH-1:0]  filled_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [POS_W-1:0]  old_left_ff, old_right_ff;
   logic              old_valid_ff;

   // oldest entry sits one past the slot being written
   assign slot_in = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff   <= '0;
         filled_ff <= '0;
      end else if (accept) begin
         slot_ff            <= slot_in;
         filled_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_left[slot_ff]  <= pos_left;
         mem_right[slot_ff] <= pos_right;
         old_left_ff        <= mem_left[slot_in];
         old_right_ff       <= mem_right[slot_in];
         old_valid_ff       <= filled_ff[slot_in];
      end
   end

   // never-written entries read as zero
   assign old_left  = old_valid_ff ? old_left_ff  : '0;
   assign old_right = old_valid_ff ? old_right_ff : '0;

endmodule

`default_nettype wire

// ----- hdl/fss_wheel.sv -----
`default_nettype none

module fss_wheel
   import fss_pkg::*;
(
   input  wire logic                    clock,
   input  wire pipe_en_type             en,
   input  wire logic [POS_W-1:0]        pos,
   input  wire logic [POS_W-1:0]        old,
   input  wire logic [31:0]             inverse_window,
   input  wire logic [TOL_W-1:0]        ready_tolerance,
   input  wire logic signed [SPD_W-1:0] held_goal,
   output logic signed [SPD_W-1:0]      average,
   output logic                         ready
);

   localparam int HALF_W = POS_W / 2;

   logic [POS_W-1:0]        diff;
   logic [POS_W-1:0]        mag_ff;
   logic                    neg2_ff, neg3_ff;
   logic [PROD_W-1:0]       lo_ff, hi_ff;
   logic [79:0]             prod;
   logic [63:0]             scaled;
   logic signed [SPD_W-1:0] avg_in, avg4_ff, avg5_ff;
   logic signed [SPD_W:0]   err;
   logic [SPD_W:0]          err_abs;
   logic                    ready_ff;

   // stage 2: wrapped difference and magnitude
   assign diff = pos - old;

   always_ff @(posedge clock) begin
      if (en.s2) begin
         neg2_ff <= diff[POS_W-1];
         mag_ff  <= diff[POS_W-1] ? (~diff + 48'd1) : diff;
      end
   end

   // stage 3: two partial products
   always_ff @(posedge clock) begin
      if (en.s3) begin
         neg3_ff <= neg2_ff;
         lo_ff   <= PROD_W'(mag_ff[HALF_W-1:0]) * PROD_W'(inverse_window);
         hi_ff   <= PROD_W'(mag_ff[POS_W-1:HALF_W]) * PROD_W'(inverse_window);
      end
   end

   // stage 4: combine, drop the fraction, saturate
   assign prod   = {hi_ff, 24'd0} + {24'd0, lo_ff};
   assign scaled = prod[79:16];

   always_comb begin
      if (neg3_ff) begin
         if (scaled > 64'd2147483648) avg_in = 32'sh8000_0000;
         else                         avg_in = $signed(~scaled[31:0] + 32'd1);
      end else begin
         if (scaled > 64'd2147483647) avg_in = 32'sh7FFF_FFFF;
         else                         avg_in = $signed(scaled[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         avg4_ff <= avg_in;
      end
   end

   // stage 5: readiness against the held goal
   assign err     = {held_goal[SPD_W-1], held_goal} - {avg4_ff[SPD_W-1], avg4_ff};
   assign err_abs = err[SPD_W] ? (~err + 33'd1) : err;

   always_ff @(posedge clock) begin
      if (en.s5) begin
         avg5_ff  <= avg4_ff;
         ready_ff <= (err_abs < {2'b00, ready_tolerance}) && (held_goal > SPEED_ONE);
      end
   end

   assign average = avg5_ff;
   assign ready   = ready_ff;

endmodule

`default_nettype wire

// ----- hdl/fss_latch.sv -----
`default_nettype none

module fss_latch
   import fss_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire side_type    side,
   input  wire logic        ready_both,
   input  wire logic [15:0] timeout_ticks,
   output drive_type        drive
);

   latch_state_type     state_ff, state_in, state_next;
   logic [SHOT_W-1:0]   shots_ff, shots_in;
   logic [TICK_W-1:0]   ticks_ff, ticks_in, ticks_inc;
   logic                timed_out;
   logic                is_pass;
   logic                count_shot;
   logic                shoot;

   assign ticks_inc = (ticks_ff == TICKS_MAX) ? ticks_ff : ticks_ff + 1'b1;
   assign timed_out = ticks_inc > {1'b0, timeout_ticks};

   // next state
   always_comb begin
      state_next = state_ff;
      is_pass    = 1'b0;
      count_shot = 1'b0;
      unique case (state_ff)
         LS_SPINDOWN: begin
            if (side.spin_low)                  state_next = LS_SPINUP;
            if (side.goal_small || timed_out)   state_next = LS_INCREMENT;
         end
         LS_SPINUP: begin
            if (side.spin_high || side.goal_small || timed_out)
               state_next = LS_INCREMENT;
         end
         LS_INCREMENT: begin
            count_shot = 1'b1;
            state_next = LS_NEGEDGE;
         end
         LS_NEGEDGE: begin
            if (!side.push) state_next = LS_PASS;
         end
         default: begin
            is_pass    = 1'b1;
            state_next = LS_PASS;
            if (side.push && side.goal_big && ready_both) state_next = LS_SPINDOWN;
         end
      endcase
   end

   // outputs
   always_comb begin
      shoot = 1'b0;
      unique case (state_ff) inside
         LS_SPINDOWN, LS_SPINUP, LS_NEGEDGE: shoot = 1'b1;
         LS_INCREMENT:                       shoot = 1'b0;
         default: shoot = side.push && (side.goal_big ? ready_both : 1'b1);
      endcase
   end

   always_comb begin
      state_in = side.drive_valid ? state_next : state_ff;
      shots_in = (side.drive_valid && count_shot && (shots_ff != SHOTS_MAX))
                 ? shots_ff + 1'b1 : shots_ff;
      ticks_in = (side.drive_valid && is_pass) ? '0 : ticks_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LS_PASS;
         shots_ff <= '0;
         ticks_ff <= TICKS_MAX;
      end else if (step) begin
         state_ff <= state_in;
         shots_ff <= shots_in;
         ticks_ff <= ticks_in;
      end
   end

   always_comb begin
      drive.lamp_on        = side.drive_valid && (side.goal_nonzero || side.force_lights);
      drive.forward_light  = side.drive_valid && side.goal_nonzero && side.forwards;
      drive.backward_light = side.drive_valid && side.goal_nonzero && !side.forwards;
      drive.clamp_drive    = side.drive_valid && side.clamp;
      drive.push_drive     = side.drive_valid && shoot;
      drive.shot_count     = shots_in;
   end

endmodule

`default_nettype wire

// ----- hdl/flywheel_shot_sequencer.sv -----
// flywheel shot sequencer: one word in, one word out per control tick
// each word passes the input register, stages 2 to 5 and the output register in turn
// throughput: one word per cycle; stall on the result side fills bubbles first
// reset (synchronous, active high): pipeline empty, ring history reads as zero,
//   held goal zero, feed latch in pass through, shot count zero, tick count saturated
`default_nettype none

module flywheel_shot_sequencer
   import fss_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   fss_chan_if.sink                   req_ch,
   fss_chan_if.source                 rsp_ch,
   input  wire logic                  csr_write_enable,
   input  wire logic [IDX_W-1:0]      csr_index,
   input  wire logic [CSR_W-1:0]      csr_write_data
);

   // configuration registers
   logic [15:0]       timeout_ff;
   logic [31:0]       inverse_ff;
   logic [TOL_W-1:0]  tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         inverse_ff   <= INVERSE_RESET;
         tolerance_ff <= TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TIMEOUT:   timeout_ff   <= csr_write_data[15:0];
            CSR_INVERSE:   inverse_ff   <= csr_write_data;
            CSR_TOLERANCE: tolerance_ff <= csr_write_data[TOL_W-1:0];
            default: ;     // unmapped index, write dropped
         endcase
      end
   end

   // stage load enables: each stage moves when it is empty or the next one moves
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en_out;
   logic accept;
   pipe_en_type en;

   assign en_out = !rsp_valid_ff || rsp_ch.ready;
   assign en5    = !v5_ff || en_out;
   assign en4    = !v4_ff || en5;
   assign en3    = !v3_ff || en4;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_ch.valid && en1;
   assign req_ch.ready = en1;

   always_comb begin
      en.s2 = en2;
      en.s3 = en3;
      en.s4 = en4;
      en.s5 = en5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff        <= req_ch.valid;
         if (en2)    v2_ff        <= v1_ff;
         if (en3)    v3_ff        <= v2_ff;
         if (en4)    v4_ff        <= v3_ff;
         if (en5)    v5_ff        <= v4_ff;
         if (en_out) rsp_valid_ff <= v5_ff;
      end
   end

   // held goal updates at intake so every later word sees it in tick order
   logic signed [SPD_W-1:0] held_goal_ff, held_goal_in;

   assign held_goal_in = req_ch.payload.goal_present ? req_ch.payload.goal_velocity
                                                      : held_goal_ff;

   always_ff @(posedge clock) begin
      if (reset)       held_goal_ff <= '0;
      else if (accept) held_goal_ff <= held_goal_in;
   end

   // stage 1: input register, ring lookup of the oldest position
   req_word_type            word1_ff;
   logic signed [SPD_W-1:0] held1_ff;
   logic [POS_W-1:0]        old_left, old_right;

   always_ff @(posedge clock) begin
      if (en1) begin
         word1_ff <= req_ch.payload;
         held1_ff <= held_goal_in;
      end
   end

   fss_ring #(
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pos_left  (req_ch.payload.position_left),
      .pos_right (req_ch.payload.position_right),
      .old_left  (old_left),
      .old_right (old_right)
   );

   // stage 2: goal and spin comparisons, exact in integers
   logic signed [36:0] g_ext, vl_ext, vr_ext;
   logic signed [36:0] g9, g19, vl10, vr10, vl20, vr20;
   side_type side_in, side2_ff, side3_ff, side4_ff, side5_ff;

   always_comb begin
      g_ext  = $signed({{5{word1_ff.goal_velocity[SPD_W-1]}}, word1_ff.goal_velocity});
      vl_ext = $signed({{5{word1_ff.velocity_left[SPD_W-1]}}, word1_ff.velocity_left});
      vr_ext = $signed({{5{word1_ff.velocity_right[SPD_W-1]}}, word1_ff.velocity_right});
      g9     = g_ext * 37'sd9;
      g19    = g_ext * 37'sd19;
      vl10   = vl_ext * 37'sd10;
      vr10   = vr_ext * 37'sd10;
      vl20   = vl_ext * 37'sd20;
      vr20   = vr_ext * 37'sd20;

      side_in.drive_valid  = word1_ff.output_enabled && word1_ff.goal_present;
      side_in.clamp        = word1_ff.clamp_request;
      side_in.push         = word1_ff.push_request;
      side_in.forwards     = word1_ff.aim_forward;
      side_in.force_lights = word1_ff.lamp_override;
      side_in.goal_nonzero = (word1_ff.goal_velocity != '0);
      // below 10 rad/s in magnitude
      side_in.goal_small   = (word1_ff.goal_velocity < SPEED_TEN)
                             && (word1_ff.goal_velocity > -SPEED_TEN);
      // above 10 rad/s in magnitude
      side_in.goal_big     = (word1_ff.goal_velocity > SPEED_TEN)
                             || (word1_ff.goal_velocity < -SPEED_TEN);
      // either wheel under 0.9 of goal
      side_in.spin_low     = (vl10 < g9) || (vr10 < g9);
      // both wheels over 0.95 of goal
      side_in.spin_high    = (vl20 > g19) && (vr20 > g19);
      side_in.held_goal    = held1_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) side2_ff <= side_in;
      if (en3) side3_ff <= side2_ff;
      if (en4) side4_ff <= side3_ff;
      if (en5) side5_ff <= side4_ff;
   end

   // stages 2 to 5: window average and readiness per wheel
   logic signed [SPD_W-1:0] average_left, average_right;
   logic                    ready_left, ready_right;

   fss_wheel u_wheel_left (
      .clock           (clock),
      .en              (en),
      .pos             (word1_ff.position_left),
      .old             (old_left),
      .inverse_window  (inverse_ff),
      .ready_tolerance (tolerance_ff),
      .held_goal       (side4_ff.held_goal),
      .average         (average_left),
      .ready           (ready_left)
   );

   fss_wheel u_wheel_right (
      .clock           (clock),
      .en              (en),
      .pos             (word1_ff.position_right),
      .old             (old_right),
      .inverse_window  (inverse_ff),
      .ready_tolerance (tolerance_ff),
      .held_goal       (side4_ff.held_goal),
      .average         (average_right),
      .ready           (ready_right)
   );

   // final stage: feed latch steps as the word enters the output register
   logic      ready_both;
   logic      step;
   drive_type drive;

   assign ready_both = ready_left && ready_right;
   assign step       = en_out && v5_ff;

   fss_latch u_latch (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .side          (side5_ff),
      .ready_both    (ready_both),
      .timeout_ticks (timeout_ff),
      .drive         (drive)
   );

   // output register
   rsp_word_type rsp_word_ff;

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_word_ff.ready_both     <= ready_both;
         rsp_word_ff.ready_left     <= ready_left;
         rsp_word_ff.ready_right    <= ready_right;
         rsp_word_ff.average_left   <= average_left;
         rsp_word_ff.average_right  <= average_right;
         rsp_word_ff.shot_count     <= drive.shot_count;
         rsp_word_ff.drive_valid    <= side5_ff.drive_valid;
         rsp_word_ff.lamp_on        <= drive.lamp_on;
         rsp_word_ff.forward_light  <= drive.forward_light;
         rsp_word_ff.backward_light <= drive.backward_light;
         rsp_word_ff.clamp_drive    <= drive.clamp_drive;
         rsp_word_ff.push_drive     <= drive.push_drive;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

endmodule

`default_nettype wire

// ----- hdl/fss_check.sv -----
`default_nettype none

module fss_check
   import fss_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_ready_both: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.ready_both == (rsp_word.ready_left && rsp_word.ready_right))
      else $error("ready_both disagrees with wheel flags");

   a_drive_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.drive_valid |->
         !(rsp_word.lamp_on || rsp_word.forward_light || rsp_word.backward_light
           || rsp_word.clamp_drive || rsp_word.push_drive))
      else $error("drive output active without drive_valid");

   a_flash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.forward_light || rsp_word.backward_light) |->
         rsp_word.lamp_on && !(rsp_word.forward_light && rsp_word.backward_light))
      else $error("flashlight state inconsistent");

endmodule

bind flywheel_shot_sequencer fss_check u_fss_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_word  (rsp_ch.payload)
);

`default_nettype wire

// ----- tb/sv/flywheel_shot_sequencer_test.sv -----
module flywheel_shot_sequencer_test;
   import fss_pkg::*;

   localparam int DEPTH = HISTORY_DEPTH_DEFAULT;
   // index past the end of the register map, writes there must change nothing
   localparam logic [IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;

   // shadow of the sequencer: rings, held goal, feed latch, shot counter
   class shot_tracker;
      logic [15:0]        timeout_ticks;
      logic [31:0]        inverse_window;
      logic [TOL_W-1:0]   ready_tolerance;
      logic [POS_W-1:0]   ring_left[DEPTH];
      logic [POS_W-1:0]   ring_right[DEPTH];
      int unsigned        slot;
      logic signed [31:0] held_goal;
      latch_state_type    latch;
      logic [SHOT_W-1:0]  shots;
      logic [TICK_W-1:0]  ticks_armed;
      rsp_word_type       due[$];
      int                 checked;
      int                 faults;
      int                 latch_visits[5];
      int                 ready_ticks;
      int                 push_ticks;

      function new();
         timeout_ticks = TIMEOUT_RESET;
         inverse_window = INVERSE_RESET;
         ready_tolerance = TOLERANCE_RESET;
         foreach (ring_left[i]) begin
            ring_left[i] = '0;
            ring_right[i] = '0;
         end
         slot = 0;
         held_goal = '0;
         latch = LS_PASS;
         shots = '0;
         ticks_armed = TICKS_MAX;
      endfunction

      function void write_register(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_TIMEOUT:   timeout_ticks = data[15:0];
            CSR_INVERSE:   inverse_window = data;
            CSR_TOLERANCE: ready_tolerance = data[TOL_W-1:0];
            default: ;
         endcase
      endfunction

      // (newest - oldest) * inverse_window >> 16, toward zero, saturated to 32 bits
      function logic signed [31:0] window_speed(logic [POS_W-1:0] newest,
                                                logic [POS_W-1:0] oldest);
         logic [POS_W-1:0] diff;
         logic [POS_W-1:0] amag;
         longint unsigned  mag;
         longint unsigned  prod;
         diff = newest - oldest;
         amag = diff[POS_W-1] ? -diff : diff;
         mag = amag;
         prod = mag * inverse_window[31:16] + ((mag * inverse_window[15:0]) >> 16);
         if (diff[POS_W-1])
            return (prod > 64'h8000_0000) ? 32'h8000_0000 : 32'(-prod);
         return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(prod);
      endfunction

      function bit wheel_ready(logic signed [31:0] avg);
         longint err;
         err = longint'(held_goal) - longint'(avg);
         if (err < 0)
            err = -err;
         return (err < longint'(ready_tolerance)) && (held_goal > SPEED_ONE);
      endfunction

      function void take_tick(req_word_type w);
         rsp_word_type r;
         longint       g;
         longint       vl;
         longint       vr;
         longint       absg;
         int unsigned  newest;
         bit           timed_out;
         r = '0;
         g = longint'($signed(w.goal_velocity));
         vl = longint'($signed(w.velocity_left));
         vr = longint'($signed(w.velocity_right));
         absg = (g < 0) ? -g : g;
         if (w.goal_present)
            held_goal = w.goal_velocity;
         ring_left[slot] = w.position_left;
         ring_right[slot] = w.position_right;
         slot = (slot + 1) % DEPTH;
         newest = (slot == 0) ? DEPTH - 1 : slot - 1;
         r.average_left = window_speed(ring_left[newest], ring_left[slot]);
         r.average_right = window_speed(ring_right[newest], ring_right[slot]);
         r.ready_left = wheel_ready(r.average_left);
         r.ready_right = wheel_ready(r.average_right);
         r.ready_both = r.ready_left && r.ready_right;
         if (ticks_armed != TICKS_MAX)
            ticks_armed++;
         r.drive_valid = w.output_enabled && w.goal_present;
         if (r.drive_valid) begin
            timed_out = ticks_armed > timeout_ticks;
            if (g != 0) begin
               r.lamp_on = 1'b1;
               r.forward_light = w.aim_forward;
               r.backward_light = !w.aim_forward;
            end
            if (w.lamp_override)
               r.lamp_on = 1'b1;
            r.clamp_drive = w.clamp_request;
            case (latch)
               LS_SPINDOWN: begin
                  r.push_drive = 1'b1;
                  if (vl * 10 < g * 9 || vr * 10 < g * 9)
                     latch = LS_SPINUP;
                  if (absg < longint'(SPEED_TEN) || timed_out)
                     latch = LS_INCREMENT;
               end
               LS_SPINUP: begin
                  r.push_drive = 1'b1;
                  if ((vl * 20 > g * 19 && vr * 20 > g * 19) ||
                      absg < longint'(SPEED_TEN) || timed_out)
                     latch = LS_INCREMENT;
               end
               LS_INCREMENT: begin
                  if (shots != SHOTS_MAX)
                     shots++;
                  latch = LS_NEGEDGE;
               end
               LS_NEGEDGE: begin
                  r.push_drive = 1'b1;
                  if (!w.push_request)
                     latch = LS_PASS;
               end
               default: begin
                  latch = LS_PASS;
                  if (w.push_request) begin
                     if (absg > longint'(SPEED_TEN)) begin
                        if (r.ready_both) begin
                           latch = LS_SPINDOWN;
                           r.push_drive = 1'b1;
                        end
                     end else begin
                        r.push_drive = 1'b1;
                     end
                  end
                  ticks_armed = '0;
               end
            endcase
         end
         r.shot_count = shots;
         latch_visits[int'(latch)]++;
         ready_ticks += r.ready_both;
         push_ticks += r.push_drive;
         due.push_back(r);
      endfunction

      function void note_fault(string msg);
         faults++;
         if (faults <= 10)
            $display("mismatch: %s", msg);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want)
            note_fault($sformatf("word %0d %s expected %h got %h", checked, name, want, seen));
      endfunction

      function void check_readout(rsp_word_type got);
         rsp_word_type want;
         if (due.size() == 0) begin
            note_fault($sformatf("word %0d arrived with nothing expected", checked));
            checked++;
            return;
         end
         want = due.pop_front();
         check_field("ready_both", want.ready_both, got.ready_both);
         check_field("ready_left", want.ready_left, got.ready_left);
         check_field("ready_right", want.ready_right, got.ready_right);
         check_field("average_left", want.average_left, got.average_left);
         check_field("average_right", want.average_right, got.average_right);
         check_field("shot_count", want.shot_count, got.shot_count);
         check_field("drive_valid", want.drive_valid, got.drive_valid);
         check_field("lamp_on", want.lamp_on, got.lamp_on);
         check_field("forward_light", want.forward_light, got.forward_light);
         check_field("backward_light", want.backward_light, got.backward_light);
         check_field("clamp_drive", want.clamp_drive, got.clamp_drive);
         check_field("push_drive", want.push_drive, got.push_drive);
         checked++;
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [IDX_W-1:0]    csr_index;
   logic [CSR_W-1:0]    csr_write_data;

   fss_chan_if #(.word_type(req_word_type)) req_ch ();
   fss_chan_if #(.word_type(rsp_word_type)) rsp_ch ();

   flywheel_shot_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   shot_tracker tracker = new();

   // idle odds in percent, changed only between phases
   int send_idle_pct;
   int recv_idle_pct;
   int words_sent;
   int cycle_count;
   // free-running wheel angles for well-formed spin-up sequences
   logic [POS_W-1:0] wheel_left;
   logic [POS_W-1:0] wheel_right;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: check every accepted word, stall at random, and once hold
   // off long enough for the pipeline to fill and push back on the input
   initial begin : result_sink
      int hold_cycles;
      bit squeezed;
      hold_cycles = 0;
      squeezed = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_readout(rsp_ch.payload);
         if (!squeezed && tracker.checked == 120) begin
            squeezed = 1'b1;
            hold_cycles = 400;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // offer one word, with random gaps ahead of it, and wait for the handshake
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      do
         @(posedge clock);
      while (!req_ch.ready);
      tracker.take_tick(w);
      words_sent++;
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task automatic apply_settings(logic [31:0] timeout_data, logic [31:0] inverse_data,
                                 logic [31:0] tolerance_data);
      write_csr(CSR_TIMEOUT, timeout_data);
      write_csr(CSR_INVERSE, inverse_data);
      write_csr(CSR_TOLERANCE, tolerance_data);
      write_csr(CSR_UNUSED, $urandom);
      csr_write_enable <= 1'b0;
   endtask

   // stop offering, let every expected word come back, then allow the pipe to empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] scaled(logic signed [31:0] goal, int pct);
      return 32'(longint'(goal) * pct / 100);
   endfunction

   // angle advance per tick that makes the window average land on the goal
   function automatic longint stride_for(logic signed [31:0] goal);
      if (tracker.inverse_window == 0)
         return longint'($urandom_range(200000));
      return (longint'(goal) * 65536) /
             ((DEPTH - 1) * longint'(tracker.inverse_window));
   endfunction

   function automatic req_word_type noise_word();
      req_word_type w;
      w.goal_present = 1'($urandom_range(1));
      w.goal_velocity = $urandom;
      w.aim_forward = 1'($urandom_range(1));
      w.lamp_override = 1'($urandom_range(1));
      w.push_request = 1'($urandom_range(1));
      w.clamp_request = 1'($urandom_range(1));
      w.output_enabled = 1'($urandom_range(1));
      w.position_left = 48'({$urandom, $urandom});
      w.position_right = 48'({$urandom, $urandom});
      w.velocity_left = $urandom;
      w.velocity_right = $urandom;
      return w;
   endfunction

   // one spin-up and shot: wheels ramp at the goal speed, push goes high,
   // the speed sags as the ball leaves, then recovers, then push drops
   task automatic shot_episode(logic signed [31:0] goal, int length, int push_at,
                               int push_len, int dip_at, int dip_len, bit clean);
      req_word_type w;
      longint       stride_left;
      longint       stride_right;
      bit           dip_both;
      bit           dipping;
      stride_left = stride_for(goal);
      // now and then one wheel lags so it never reaches the goal
      stride_right = (!clean && $urandom_range(9) == 0) ? stride_left / 2 : stride_left;
      dip_both = clean || $urandom_range(1);
      for (int t = 0; t < length; t++) begin
         dipping = (t >= dip_at) && (t < dip_at + dip_len);
         w.goal_present = clean || ($urandom_range(19) != 0);
         w.goal_velocity = goal;
         w.aim_forward = 1'($urandom_range(1));
         w.lamp_override = ($urandom_range(7) == 0);
         w.push_request = (t >= push_at) && (t < push_at + push_len);
         w.clamp_request = 1'($urandom_range(1));
         w.output_enabled = clean || ($urandom_range(19) != 0);
         wheel_left = wheel_left + 48'(stride_left + longint'($urandom_range(2000)) - 1000);
         wheel_right = wheel_right + 48'(stride_right + longint'($urandom_range(2000)) - 1000);
         w.position_left = wheel_left;
         w.position_right = wheel_right;
         w.velocity_left = scaled(goal, dipping ? $urandom_range(60, 88) : $urandom_range(96, 104));
         w.velocity_right = scaled(goal, (dipping && dip_both) ? $urandom_range(60, 88)
                                                             : $urandom_range(96, 104));
         send_word(w);
      end
   endtask

   // corner ticks, then one clean shot from pass through back to pass through
   task automatic run_directed();
      req_word_type w;
      w = '0;
      send_word(w);
      // largest positive everything: ring jump saturates high, both wheels ready
      w = '1;
      w.goal_velocity = 32'h7FFF_FFFF;
      w.position_left = 48'h7FFF_FFFF_FFFF;
      w.position_right = 48'h7FFF_FFFF_FFFF;
      w.velocity_left = 32'h7FFF_FFFF;
      w.velocity_right = 32'h7FFF_FFFF;
      send_word(w);
      // most negative everything: saturates low, speed sag while spinning down
      w = '1;
      w.aim_forward = 1'b0;
      w.goal_velocity = 32'h8000_0000;
      w.position_left = 48'h8000_0000_0000;
      w.position_right = 48'h8000_0000_0000;
      w.velocity_left = 32'h8000_0000;
      w.velocity_right = 32'h8000_0000;
      send_word(w);
      // zero goal: flashlights dark, lights only when forced
      w = '0;
      w.goal_present = 1'b1;
      w.output_enabled = 1'b1;
      w.aim_forward = 1'b1;
      w.push_request = 1'b1;
      send_word(w);
      w.lamp_override = 1'b1;
      send_word(w);
      // drive not valid, once per missing flag
      w = '1;
      w.goal_present = 1'b0;
      send_word(w);
      w = '1;
      w.output_enabled = 1'b0;
      send_word(w);
      // goal right at and just over the ten rad/s push threshold
      w = '0;
      w.goal_present = 1'b1;
      w.output_enabled = 1'b1;
      w.push_request = 1'b1;
      w.goal_velocity = SPEED_TEN;
      send_word(w);
      w.goal_velocity = -SPEED_TEN;
      send_word(w);
      w.goal_velocity = SPEED_TEN + 1;
      send_word(w);
      shot_episode(32'sd300 * SPEED_ONE, 15, 8, 6, 9, 2, 1'b1);
   endtask

   task automatic run_random(int quota);
      int                 stop_at;
      int                 kind;
      logic signed [31:0] goal;
      stop_at = words_sent + quota;
      while (words_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            repeat ($urandom_range(1, 5)) send_word(noise_word());
         end else begin
            if (kind < 75) begin
               goal = $urandom_range(20 * 65536, 600 * 65536);
            end else if (kind < 85) begin
               goal = $urandom_range(2 * 655360);
               goal = goal - SPEED_TEN;
            end else if (kind < 93) begin
               goal = $urandom_range(20 * 65536, 600 * 65536);
               goal = -goal;
            end else begin
               goal = $urandom;
            end
            shot_episode(goal, $urandom_range(12, 32), $urandom_range(4, 12),
                         $urandom_range(2, 14), $urandom_range(9, 16),
                         $urandom_range(0, 4), 1'b0);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= '0;
      csr_write_data <= '0;
      words_sent = 0;
      wheel_left = 48'({$urandom, $urandom});
      wheel_right = 48'({$urandom, $urandom});
      send_idle_pct = 25;
      recv_idle_pct = 68;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings; the long result stall lands in this phase
      run_directed();
      run_random(300);
      settle();

      // zero timeout, widest window gain, loosest tolerance; high data bits dropped
      apply_settings(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(150);
      settle();

      // longest timeout, zero gain, zero tolerance; swap the idle odds
      send_idle_pct = 68;
      recv_idle_pct = 25;
      apply_settings(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000);
      run_random(150);
      settle();

      // short timeout so sequences time out mid-shot
      apply_settings(32'd5, INVERSE_RESET, 32'h8000_0000 | 32'(TOLERANCE_RESET));
      run_random(250);
      settle();

      // no idling at all, twice the window, wider tolerance
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(32'd30, INVERSE_RESET / 2, 32'd1310720);
      run_random(250);
      settle();

      if (tracker.pending() != 0)
         tracker.note_fault($sformatf("%0d words never came back", tracker.pending()));
      $display("covered %0d ticks over five register settings, %0d shots counted, %0d push ticks",
               words_sent, tracker.shots, tracker.push_ticks);
      $display("latch ticks pass/spindown/spinup/count/release %0d/%0d/%0d/%0d/%0d, %0d both-ready",
               tracker.latch_visits[LS_PASS], tracker.latch_visits[LS_SPINDOWN],
               tracker.latch_visits[LS_SPINUP], tracker.latch_visits[LS_INCREMENT],
               tracker.latch_visits[LS_NEGEDGE], tracker.ready_ticks);
      if (tracker.faults == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
